// ----- design/dmh_pkg.sv -----
`timescale 1ns / 1ps
package dmh_pkg;

  localparam int NUM_BINS_DEF    = 32;
  localparam int COUNT_WIDTH_DEF = 32;
  localparam int BIN_ROM_SIZE    = 32;
  localparam int MAG_W           = 63;
  localparam int OUT_COUNT_W     = 32;
  localparam int OUT_BIN_W       = 5;

  localparam logic [MAG_W-1:0] FIRST_BOUND = 63'h3C9CD2B297D889BC;
  localparam logic        FUNC_ADD  = 1'b0;
  localparam logic        FUNC_READ = 1'b1;

  typedef struct packed {
    logic        func;
    logic [63:0] sample_bits;
    logic [4:0]  bin_index;
  } in_item_t;

  typedef struct packed {
    logic [4:0]       sample_bin;
    logic [31:0]      bin_count;
    logic [MAG_W-1:0] min_magnitude;
    logic [MAG_W-1:0] max_magnitude;
    logic             has_data;
  } out_item_t;

  // multiply a positive normal double by ten, round to nearest even
  function automatic logic [MAG_W-1:0] mul_ten(logic [MAG_W-1:0] a);
    logic [10:0] e;
    logic [52:0] m;
    logic [56:0] p;
    logic [53:0] keep;
    logic        guard;
    logic        sticky;
    e = a[62:52];
    m = {1'b1, a[51:0]};
    p = 57'(m) * 57'd10;
    if (p[56]) begin
      keep   = {1'b0, p[56:4]};
      guard  = p[3];
      sticky = |p[2:0];
      e      = e + 11'd4;
    end else begin
      keep   = {1'b0, p[55:3]};
      guard  = p[2];
      sticky = |p[1:0];
      e      = e + 11'd3;
    end
    if (guard && (sticky || keep[0])) keep = keep + 54'd1;
    if (keep[53]) begin
      keep = keep >> 1;
      e    = e + 11'd1;
    end
    return {e, keep[51:0]};
  endfunction

  function automatic logic [MAG_W-1:0] decade_bound(int i);
    logic [MAG_W-1:0] b;
    b = FIRST_BOUND;
    for (int k = 0; k < BIN_ROM_SIZE; k++) begin
      if (k < i) b = mul_ten(b);
    end
    return b;
  endfunction

  function automatic logic is_nan(logic [MAG_W-1:0] m);
    return (m[62:52] == 11'h7FF) && (m[51:0] != 52'd0);
  endfunction

endpackage

// ----- design/decade_magnitude_histogram.sv -----
`timescale 1ns / 1ps
// Decade magnitude histogram.
// Input channel: drive in_item with start high; an item is taken at any edge
// with start high and busy low. busy is always low, so an item may be given
// every cycle. func 0 adds the double in sample_bits to one of NUM_BINS decade
// bins by its magnitude and tracks the smallest and largest magnitude; func 1
// reads the count of bin_index together with the extremes.
// Result channel: each item gives one result on out_item with out_valid high
// for exactly one cycle; the item passes an input register and then a result
// register before out_valid rises.
// The block takes one item per cycle; the bin search is NUM_BINS constant
// compares and one counter update in a single stage.
// The receiver cannot stall; results must be taken as they come.
// Reset (rst_n low at a clock edge) clears all bin counters, the extremes and
// the has_data flag, and drops any item in flight.
module decade_magnitude_histogram #(
  parameter int NUM_BINS    = dmh_pkg::NUM_BINS_DEF,
  parameter int COUNT_WIDTH = dmh_pkg::COUNT_WIDTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  dmh_pkg::in_item_t  in_item,
  output logic               out_valid,
  output dmh_pkg::out_item_t out_item
);

  localparam int BW = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;
  localparam int MW = dmh_pkg::MAG_W;

  logic                   in_valid_r;
  dmh_pkg::in_item_t      in_r;
  logic [COUNT_WIDTH-1:0] counts_r [NUM_BINS];
  logic [MW-1:0]          min_r, min_nxt;
  logic [MW-1:0]          max_r, max_nxt;
  logic                   seen_r, seen_nxt;
  logic                   out_valid_r;
  dmh_pkg::out_item_t     out_r, out_nxt;

  logic [MW-1:0]          mag;
  logic                   mag_nan;
  logic [BW-1:0]          bin;
  logic [BW-1:0]          addr;
  logic                   addr_ok;
  logic [COUNT_WIDTH-1:0] cnt;
  logic [63:0]            cnt_ext;
  logic                   do_add;

  assign busy      = 1'b0;
  assign out_valid = out_valid_r;
  assign out_item  = out_r;

  assign mag     = in_r.sample_bits[MW-1:0];
  assign mag_nan = dmh_pkg::is_nan(mag);
  assign do_add  = in_valid_r && (in_r.func == dmh_pkg::FUNC_ADD);

  always_comb begin
    bin = '0;
    for (int i = 0; i < NUM_BINS; i++) begin
      if (!mag_nan && (mag >= dmh_pkg::decade_bound(i))) bin = BW'(i);
    end
  end

  always_comb begin
    if (in_r.func == dmh_pkg::FUNC_ADD) begin
      addr    = bin;
      addr_ok = 1'b1;
    end else begin
      addr    = in_r.bin_index[BW-1:0];
      addr_ok = (32'(in_r.bin_index) < 32'(NUM_BINS));
    end
    cnt     = counts_r[addr];
    cnt_ext = 64'(cnt);
  end

  always_comb begin
    min_nxt  = min_r;
    max_nxt  = max_r;
    seen_nxt = seen_r;
    if (do_add) begin
      if (!seen_r) begin
        min_nxt  = mag;
        max_nxt  = mag;
        seen_nxt = 1'b1;
      end else if (!mag_nan) begin
        if (!dmh_pkg::is_nan(max_r) && (mag > max_r)) max_nxt = mag;
        if (!dmh_pkg::is_nan(min_r) && (mag < min_r)) min_nxt = mag;
      end
    end
    out_nxt.sample_bin    = '0;
    out_nxt.bin_count     = '0;
    if (in_r.func == dmh_pkg::FUNC_ADD) begin
      out_nxt.sample_bin = dmh_pkg::OUT_BIN_W'(bin);
    end else if (addr_ok) begin
      out_nxt.bin_count = cnt_ext[dmh_pkg::OUT_COUNT_W-1:0];
    end
    out_nxt.min_magnitude = min_nxt;
    out_nxt.max_magnitude = max_nxt;
    out_nxt.has_data      = seen_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      min_r       <= '0;
      max_r       <= '0;
      seen_r      <= 1'b0;
      for (int i = 0; i < NUM_BINS; i++) counts_r[i] <= '0;
    end else begin
      in_valid_r  <= start;
      out_valid_r <= in_valid_r;
      min_r       <= min_nxt;
      max_r       <= max_nxt;
      seen_r      <= seen_nxt;
      if (do_add && (cnt != {COUNT_WIDTH{1'b1}})) begin
        counts_r[bin] <= cnt + COUNT_WIDTH'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) in_r <= in_item;
    if (in_valid_r) out_r <= out_nxt;
  end

endmodule
